[rtl/core/integer_to_ascii_formatter_defines.svh]
// Assertion macros for the integer to ASCII formatter checker.
// Both macros sample on the rising edge of clk; the first is masked while rst_n is low.
`ifndef INTEGER_TO_ASCII_FORMATTER_DEFINES_SVH
`define INTEGER_TO_ASCII_FORMATTER_DEFINES_SVH

// check a property outside reset
`define ITOA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check a property at every edge, reset included
`define ITOA_ASSERT_ALL(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/core/itoa_pkg.sv]
// Shared types, codes and character constants for the integer to ASCII formatter.
// No dependencies.
package itoa_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int IN_BITS        = 32;

    typedef logic [1:0] cmd_t;
    typedef logic [7:0] char_t;
    typedef logic [3:0] digit_t;

    localparam cmd_t CMD_SDEC = 2'd0;
    localparam cmd_t CMD_UDEC = 2'd1;
    localparam cmd_t CMD_HEX  = 2'd2;
    localparam cmd_t CMD_PTR  = 2'd3;

    localparam char_t CH_ZERO  = 8'h30;
    localparam char_t CH_A     = 8'h61;
    localparam char_t CH_MINUS = 8'h2d;
    localparam char_t CH_X     = 8'h78;

    typedef struct packed {
        logic clear;
        logic load_hex;
        logic dabble;
        logic shift_out;
        logic dec_mode;
    } dctl_t;

    function automatic char_t digit_char(digit_t d);
        if (d < 4'd10)
        begin
            return CH_ZERO + char_t'(d);
        end
        return CH_A + char_t'(d - 4'd10);
    endfunction

endpackage

[rtl/core/itoa_digits.sv]
// Digit shift register: bit-serial binary to BCD (shift and add three) or direct hex load,
// then shifted out one digit per cycle from the top. Depends on itoa_pkg.
module itoa_digits #(
    parameter int VALUE_BITS = itoa_pkg::VALUE_BITS_DEF,
    parameter int NDEC       = 10,
    parameter int NHEX       = 8
) (
    input  logic                  clk,
    input  itoa_pkg::dctl_t       ctl,
    input  logic                  bit_in,
    input  logic [VALUE_BITS-1:0] hex_val,
    output itoa_pkg::digit_t      top_digit
);
    import itoa_pkg::*;

    localparam int NDIG = (NDEC > NHEX) ? NDEC : NHEX;
    localparam int W    = 4 * NDIG;

    logic [W-1:0] dig_reg;
    logic [W-1:0] dig_next;
    logic [W-1:0] adj;

    always_comb
    begin
        for (int i = 0; i < NDIG; i++)
        begin
            if (dig_reg[4*i +: 4] >= 4'd5)
            begin
                adj[4*i +: 4] = dig_reg[4*i +: 4] + 4'd3;
            end
            else
            begin
                adj[4*i +: 4] = dig_reg[4*i +: 4];
            end
        end
    end

    always_comb
    begin
        dig_next = dig_reg;
        if (ctl.clear)
        begin
            dig_next = '0;
        end
        else if (ctl.load_hex)
        begin
            dig_next = W'(hex_val);
        end
        else if (ctl.dabble)
        begin
            dig_next = {adj[W-2:0], bit_in};
        end
        else if (ctl.shift_out)
        begin
            dig_next = {dig_reg[W-5:0], 4'h0};
        end
    end

    always_ff @(posedge clk)
    begin
        dig_reg <= dig_next;
    end

    assign top_digit = ctl.dec_mode ? dig_reg[4*NDEC-1 -: 4] : dig_reg[4*NHEX-1 -: 4];

endmodule

[rtl/core/integer_to_ascii_formatter.sv]
// Integer to ASCII formatter top level: command port, sequencer and character output register.
// Depends on itoa_pkg and itoa_digits.
//
// A number is taken when start is high and busy is low; its characters then appear one per
// strobe, most significant first, and the receiver must take each one in the cycle it is shown.
// Decimal modes first run the bit-serial conversion, then show a minus sign if needed and
// scan the digit slots (10 slots at 32 bits). Hex modes skip the conversion and scan one
// slot per nibble (8 at 32 bits); pointer mode first shows the 0x prefix. Leading zeros are
// dropped in the digit scan: those slots give no strobe, but the final digit is always shown.
// busy falls in the cycle the last character is shown, and a new start may be given in that
// same cycle.
module integer_to_ascii_formatter #(
    parameter int VALUE_BITS = itoa_pkg::VALUE_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  itoa_pkg::cmd_t                 cmd,
    input  logic [itoa_pkg::IN_BITS-1:0]   value,
    output logic                           busy,
    output logic                           strobe,
    output itoa_pkg::char_t                ascii_char,
    output logic                           last
);
    import itoa_pkg::*;

    localparam int NDEC = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int NHEX = (VALUE_BITS + 3) / 4;
    localparam int CW   = $clog2(VALUE_BITS + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_PFX  = 2'd2;
    localparam logic [1:0] ST_DIG  = 2'd3;

    logic [1:0]            state_reg, state_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [VALUE_BITS-1:0] mag_reg, mag_next;
    logic                  dec_reg, dec_next;
    logic                  dash_reg, dash_next;
    logic                  pz_reg, pz_next;
    logic                  px_reg, px_next;
    logic                  seen_reg, seen_next;
    logic                  strobe_reg, strobe_next;
    logic                  last_reg, last_next;
    char_t                 char_reg, char_next;

    logic [VALUE_BITS-1:0] val_w;
    logic [VALUE_BITS-1:0] val_neg;
    logic                  accept;
    logic                  in_dec;
    logic                  in_dash;
    dctl_t                 dctl;
    digit_t                top_digit;

    generate
        if (VALUE_BITS <= IN_BITS)
        begin : g_trim
            assign val_w = value[VALUE_BITS-1:0];
        end
        else
        begin : g_extend
            assign val_w = {{(VALUE_BITS-IN_BITS){1'b0}}, value};
        end
    endgenerate

    assign val_neg = ~val_w + {{(VALUE_BITS-1){1'b0}}, 1'b1};
    assign accept  = start && (state_reg == ST_IDLE);
    assign in_dec  = (cmd == CMD_SDEC) || (cmd == CMD_UDEC);
    assign in_dash = (cmd == CMD_SDEC) && val_w[VALUE_BITS-1];

    itoa_digits #(
        .VALUE_BITS (VALUE_BITS),
        .NDEC       (NDEC),
        .NHEX       (NHEX)
    ) u_digits (
        .clk       (clk),
        .ctl       (dctl),
        .bit_in    (mag_reg[VALUE_BITS-1]),
        .hex_val   (val_w),
        .top_digit (top_digit)
    );

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        mag_next    = mag_reg;
        dec_next    = dec_reg;
        dash_next   = dash_reg;
        pz_next     = pz_reg;
        px_next     = px_reg;
        seen_next   = seen_reg;
        strobe_next = 1'b0;
        last_next   = 1'b0;
        char_next   = char_reg;
        dctl        = '0;
        dctl.dec_mode = dec_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    dec_next  = in_dec;
                    dash_next = in_dash;
                    pz_next   = (cmd == CMD_PTR);
                    px_next   = (cmd == CMD_PTR);
                    seen_next = 1'b0;
                    mag_next  = in_dash ? val_neg : val_w;
                    if (in_dec)
                    begin
                        dctl.clear = 1'b1;
                        cnt_next   = CW'(VALUE_BITS);
                        state_next = ST_CONV;
                    end
                    else
                    begin
                        dctl.load_hex = 1'b1;
                        cnt_next      = CW'(NHEX);
                        state_next    = (cmd == CMD_PTR) ? ST_PFX : ST_DIG;
                    end
                end
            end
            ST_CONV:
            begin
                dctl.dabble = 1'b1;
                mag_next    = {mag_reg[VALUE_BITS-2:0], 1'b0};
                cnt_next    = cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    cnt_next   = CW'(NDEC);
                    state_next = dash_reg ? ST_PFX : ST_DIG;
                end
            end
            ST_PFX:
            begin
                strobe_next = 1'b1;
                if (dash_reg)
                begin
                    char_next  = CH_MINUS;
                    dash_next  = 1'b0;
                    state_next = ST_DIG;
                end
                else if (pz_reg)
                begin
                    char_next = CH_ZERO;
                    pz_next   = 1'b0;
                end
                else
                begin
                    char_next  = CH_X;
                    px_next    = 1'b0;
                    state_next = ST_DIG;
                end
            end
            ST_DIG:
            begin
                dctl.shift_out = 1'b1;
                cnt_next       = cnt_reg - 1'b1;
                // drop leading zeros, keep the final digit
                if (seen_reg || (top_digit != 4'd0) || (cnt_reg == CW'(1)))
                begin
                    strobe_next = 1'b1;
                    char_next   = digit_char(top_digit);
                    last_next   = (cnt_reg == CW'(1));
                    seen_next   = 1'b1;
                end
                if (cnt_reg == CW'(1))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            strobe_reg <= 1'b0;
            last_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
            last_reg   <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        mag_reg  <= mag_next;
        dec_reg  <= dec_next;
        dash_reg <= dash_next;
        pz_reg   <= pz_next;
        px_reg   <= px_next;
        seen_reg <= seen_next;
        char_reg <= char_next;
    end

    assign busy       = (state_reg != ST_IDLE);
    assign strobe     = strobe_reg;
    assign ascii_char = char_reg;
    assign last       = last_reg;

endmodule

[rtl/core/itoa_checker.sv]
// Port-level checker for the integer to ASCII formatter, bound to the top level.
// Depends on itoa_pkg and integer_to_ascii_formatter_defines.svh.
`include "integer_to_ascii_formatter_defines.svh"

module itoa_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         strobe,
    input itoa_pkg::char_t              ascii_char,
    input logic                         last
);
    `ITOA_ASSERT_ALL(a_reset_quiet, !rst_n |=> (!strobe && !busy), "activity during reset")
    `ITOA_ASSERT(a_start_busy, (start && !busy) |=> busy, "word taken but busy stayed low")
    `ITOA_ASSERT(a_mid_busy, (strobe && !last) |-> (busy && !$isunknown(ascii_char)), "character shown while idle or unknown")
    `ITOA_ASSERT(a_fell_last, $fell(busy) |-> (strobe && last), "busy fell without final word")
    `ITOA_ASSERT(a_gap_after_last, (strobe && last) |=> !strobe, "word right after final word")

endmodule

bind integer_to_ascii_formatter itoa_checker u_itoa_checker (.*);
